// ===== rtl/dpvfp_pkg.sv =====
`default_nettype none

package dpvfp_pkg;

  localparam logic [7:0] HEAD_A         = 8'hAA;
  localparam logic [7:0] TAIL_A         = 8'h55;
  localparam logic [7:0] HEAD_B1        = 8'h2C;
  localparam logic [7:0] HEAD_B2        = 8'h12;
  localparam logic [7:0] TAIL_B         = 8'h5B;
  localparam logic [7:0] FIXED_CONF_B   = 8'd100;
  localparam logic [7:0] MIN_DIGIT      = 8'd1;
  localparam logic [7:0] MAX_DIGIT      = 8'd8;
  localparam logic [7:0] SIDE_MAX       = 8'd2;
  localparam logic [7:0] FOUND_YES      = 8'd1;
  localparam logic [7:0] REPEAT_CAP     = 8'd255;
  localparam logic [7:0] MIN_CONF_RST   = 8'd55;
  localparam logic [7:0] STABLE_REP_RST = 8'd1;
  localparam logic [7:0] TARGET_RST     = 8'd0;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CONF   = 2'd0,
    CFG_STABLE_REP = 2'd1,
    CFG_TARGET     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] min_conf;
    logic [7:0] stable_rep;
    logic [7:0] target;
  } cfg_t;

  typedef struct packed {
    logic       acc;
    logic       err;
    logic [7:0] room;
    logic [7:0] side;
    logic [7:0] found;
    logic [7:0] task_num;
    logic [7:0] conf;
  } frame_t;

  // Packed LSB-last, so frame_accepted lands in bit 0 of the beat.
  typedef struct packed {
    logic [31:0] checksum_error_count;
    logic [31:0] packet_count;
    logic        target_matched;
    logic [3:0]  locked_digit;
    logic        locked_flag;
    logic [7:0]  confidence;
    logic [7:0]  task_number;
    logic [7:0]  found_flag;
    logic [7:0]  side;
    logic [7:0]  room;
    logic        checksum_error;
    logic        frame_accepted;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== rtl/dual_protocol_vision_frame_parser.sv =====
// Byte-stream parser for two vision result frame formats.
// Slave stream: one received byte per beat in s_axis_tdata; s_axis_tuser set
// means a clear request (stable digit and repeat count) and the byte is ignored.
// Master stream: one result beat per input beat, showing the frame flags of
// that byte and the latest frame fields, stability state and 32-bit counters.
// Config channel: cfg_index_i selects min confidence (0), stable repeats (1)
// or target digit (2); cfg_ready_o is always high; write only while idle.
// Path: a byte accepted into the input register is parsed and tracked there, and
// its result beat is loaded into the result register, which drives the master side.
// Throughput: one byte per cycle while result beats are taken, set by the
// combinational parse and tracking update between the two registers.
// Stall: a held result keeps its beat; one more byte can sit in the input
// register, after which s_axis_tready drops until the result is taken.
// Reset: parser idle, all fields, counters and stable state zero, config
// registers at their defaults, both streams empty.
`default_nettype none

module dual_protocol_vision_frame_parser
  import dpvfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // rx_byte[7:0]
  input  logic                 s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RES_W-1:0]     m_axis_tdata,   // frame_accepted, checksum_error, room[7:0],
                                               // side[7:0], found_flag[7:0], task_number[7:0],
                                               // confidence[7:0], locked_flag,
                                               // locked_digit[3:0], target_matched,
                                               // packet_count[31:0], checksum_error_count[31:0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  logic       in_vld_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    res_q;
  result_t    res_d;
  cfg_t       cfg_q;
  frame_t     frame;
  logic       advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_conf   <= MIN_CONF_RST;
      cfg_q.stable_rep <= STABLE_REP_RST;
      cfg_q.target     <= TARGET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_CONF:   cfg_q.min_conf   <= cfg_data_i;
        CFG_STABLE_REP: cfg_q.stable_rep <= cfg_data_i;
        CFG_TARGET:     cfg_q.target     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  dpvfp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .clr_i   (in_mode_q),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  dpvfp_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .clr_i   (in_mode_q),
    .frame_i (frame),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

endmodule

`default_nettype wire

// ===== rtl/dpvfp_parser.sv =====
`default_nettype none

module dpvfp_parser
  import dpvfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       clr_i,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_A_ROOM = 4'd1;
  localparam logic [3:0] ST_A_SIDE = 4'd2;
  localparam logic [3:0] ST_A_CONF = 4'd3;
  localparam logic [3:0] ST_A_SUM  = 4'd4;
  localparam logic [3:0] ST_A_TAIL = 4'd5;
  localparam logic [3:0] ST_B_HD2  = 4'd10;
  localparam logic [3:0] ST_B_ROOM = 4'd11;
  localparam logic [3:0] ST_B_SIDE = 4'd12;
  localparam logic [3:0] ST_B_FND  = 4'd13;
  localparam logic [3:0] ST_B_TASK = 4'd14;
  localparam logic [3:0] ST_B_TAIL = 4'd15;

  logic [3:0] state_q, state_d;
  logic [7:0] room_q, room_d;
  logic [7:0] side_q, side_d;
  logic [7:0] conf_q, conf_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] found_q, found_d;
  logic [7:0] task_q, task_d;
  logic [7:0] sum_exp;

  assign sum_exp = 8'(HEAD_A + room_q + side_q + conf_q);

  always_comb begin
    state_d = state_q;
    room_d  = room_q;
    side_d  = side_q;
    conf_d  = conf_q;
    sum_d   = sum_q;
    found_d = found_q;
    task_d  = task_q;
    frame_o = '0;
    if (step_i && !clr_i) begin
      case (state_q)
        ST_IDLE: begin
          if (byte_i == HEAD_A) begin
            state_d = ST_A_ROOM;
          end else if (byte_i == HEAD_B1) begin
            state_d = ST_B_HD2;
          end
        end
        ST_A_ROOM: begin
          room_d  = byte_i;
          state_d = ST_A_SIDE;
        end
        ST_A_SIDE: begin
          side_d  = byte_i;
          state_d = ST_A_CONF;
        end
        ST_A_CONF: begin
          conf_d  = byte_i;
          state_d = ST_A_SUM;
        end
        ST_A_SUM: begin
          sum_d   = byte_i;
          state_d = ST_A_TAIL;
        end
        ST_A_TAIL: begin
          if (byte_i == TAIL_A) begin
            frame_o.acc = (sum_q == sum_exp);
            frame_o.err = (sum_q != sum_exp);
          end
          frame_o.room     = room_q;
          frame_o.side     = side_q;
          frame_o.found    = FOUND_YES;
          frame_o.task_num = '0;
          frame_o.conf     = conf_q;
          state_d          = ST_IDLE;
        end
        ST_B_HD2: begin
          state_d = (byte_i == HEAD_B2) ? ST_B_ROOM : ST_IDLE;
        end
        ST_B_ROOM: begin
          room_d  = byte_i;
          state_d = ST_B_SIDE;
        end
        ST_B_SIDE: begin
          side_d  = byte_i;
          state_d = ST_B_FND;
        end
        ST_B_FND: begin
          found_d = byte_i;
          state_d = ST_B_TASK;
        end
        ST_B_TASK: begin
          task_d  = byte_i;
          state_d = ST_B_TAIL;
        end
        ST_B_TAIL: begin
          frame_o.acc      = (byte_i == TAIL_B);
          frame_o.room     = room_q;
          frame_o.side     = side_q;
          frame_o.found    = found_q;
          frame_o.task_num = task_q;
          frame_o.conf     = FIXED_CONF_B;
          state_d          = ST_IDLE;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      room_q  <= '0;
      side_q  <= '0;
      conf_q  <= '0;
      sum_q   <= '0;
      found_q <= '0;
      task_q  <= '0;
    end else begin
      state_q <= state_d;
      room_q  <= room_d;
      side_q  <= side_d;
      conf_q  <= conf_d;
      sum_q   <= sum_d;
      found_q <= found_d;
      task_q  <= task_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpvfp_tracker.sv =====
`default_nettype none

module dpvfp_tracker
  import dpvfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    clr_i,
  input  frame_t  frame_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [7:0]  room_q, room_d;
  logic [7:0]  side_q, side_d;
  logic [7:0]  found_q, found_d;
  logic [7:0]  task_q, task_d;
  logic [7:0]  conf_q, conf_d;
  logic [7:0]  cand_q, cand_d;
  logic [7:0]  rep_q, rep_d;
  logic [3:0]  digit_q, digit_d;
  logic        ready_q, ready_d;
  logic [31:0] pkt_q, pkt_d;
  logic [31:0] errs_q, errs_d;
  logic        qualify;
  logic        live;

  assign live    = step_i && !clr_i;
  assign qualify = (frame_i.found == FOUND_YES) && (frame_i.room >= MIN_DIGIT) &&
                   (frame_i.room <= MAX_DIGIT) && (frame_i.side <= SIDE_MAX) &&
                   (frame_i.conf >= cfg_i.min_conf);

  always_comb begin
    room_d  = room_q;
    side_d  = side_q;
    found_d = found_q;
    task_d  = task_q;
    conf_d  = conf_q;
    cand_d  = cand_q;
    rep_d   = rep_q;
    digit_d = digit_q;
    ready_d = ready_q;
    pkt_d   = pkt_q;
    errs_d  = errs_q;
    if (step_i && clr_i) begin
      cand_d  = '0;
      rep_d   = '0;
      digit_d = '0;
      ready_d = 1'b0;
    end else if (live) begin
      if (frame_i.err) begin
        errs_d = errs_q + 32'd1;
      end
      if (frame_i.acc) begin
        room_d  = frame_i.room;
        side_d  = frame_i.side;
        found_d = frame_i.found;
        task_d  = frame_i.task_num;
        conf_d  = frame_i.conf;
        pkt_d   = pkt_q + 32'd1;
        if (qualify) begin
          if (cand_q == frame_i.room) begin
            rep_d = (rep_q != REPEAT_CAP) ? rep_q + 8'd1 : rep_q;
          end else begin
            cand_d = frame_i.room;
            rep_d  = 8'd1;
          end
          if (rep_d >= cfg_i.stable_rep) begin
            digit_d = frame_i.room[3:0];
            ready_d = 1'b1;
          end
        end else begin
          cand_d = '0;
          rep_d  = '0;
        end
      end
    end
  end

  always_comb begin
    res_o.frame_accepted       = live && frame_i.acc;
    res_o.checksum_error       = live && frame_i.err;
    res_o.room                 = room_d;
    res_o.side                 = side_d;
    res_o.found_flag           = found_d;
    res_o.task_number          = task_d;
    res_o.confidence           = conf_d;
    res_o.locked_flag          = ready_d;
    res_o.locked_digit         = digit_d;
    res_o.target_matched       = (found_d == FOUND_YES) && (room_d == cfg_i.target) &&
                                 (room_d >= MIN_DIGIT) && (room_d <= MAX_DIGIT);
    res_o.packet_count         = pkt_d;
    res_o.checksum_error_count = errs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q  <= '0;
      side_q  <= '0;
      found_q <= '0;
      task_q  <= '0;
      conf_q  <= '0;
      cand_q  <= '0;
      rep_q   <= '0;
      digit_q <= '0;
      ready_q <= 1'b0;
      pkt_q   <= '0;
      errs_q  <= '0;
    end else begin
      room_q  <= room_d;
      side_q  <= side_d;
      found_q <= found_d;
      task_q  <= task_d;
      conf_q  <= conf_d;
      cand_q  <= cand_d;
      rep_q   <= rep_d;
      digit_q <= digit_d;
      ready_q <= ready_d;
      pkt_q   <= pkt_d;
      errs_q  <= errs_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpvfp_checker.sv =====
`default_nettype none

module dpvfp_checker
  import dpvfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [RES_W-1:0] m_axis_tdata
);

  result_t res;

  assign res = m_axis_tdata;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte did not produce a result beat in time");

  a_acc_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.frame_accepted && res.checksum_error))
    else $error("frame flagged both accepted and checksum failure");

  a_locked_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.locked_flag == (res.locked_digit != 4'd0)) &&
                      (res.locked_digit <= MAX_DIGIT[3:0]))
    else $error("stable digit inconsistent with stable flag");

endmodule

bind dual_protocol_vision_frame_parser dpvfp_checker u_dpvfp_checker (.*);

`default_nettype wire

// ===== verif/dual_protocol_vision_frame_parser_tb.sv =====
`timescale 1ns / 100ps

import dpvfp_pkg::*;

typedef enum logic [3:0] {
  PS_IDLE    = 4'd0,
  PS_A_ROOM  = 4'd1,
  PS_A_SIDE  = 4'd2,
  PS_A_CONF  = 4'd3,
  PS_A_SUM   = 4'd4,
  PS_A_TAIL  = 4'd5,
  PS_B_HEAD2 = 4'd10,
  PS_B_ROOM  = 4'd11,
  PS_B_SIDE  = 4'd12,
  PS_B_FOUND = 4'd13,
  PS_B_TASK  = 4'd14,
  PS_B_TAIL  = 4'd15
} parse_e;

class frame_result_tracker;
  logic [7:0] min_conf;
  logic [7:0] stable_rep;
  logic [7:0] target;
  parse_e     pstate;
  logic [7:0] h_room, h_side, h_conf, h_sum, h_found, h_task;
  logic [7:0] cand_digit;
  logic [7:0] cand_reps;
  result_t    latest;
  result_t    pending_results[$];
  int         errors;

  function new();
    min_conf   = MIN_CONF_RST;
    stable_rep = STABLE_REP_RST;
    target     = TARGET_RST;
    pstate     = PS_IDLE;
    h_room     = '0;
    h_side     = '0;
    h_conf     = '0;
    h_sum      = '0;
    h_found    = '0;
    h_task     = '0;
    cand_digit = '0;
    cand_reps  = '0;
    latest     = '0;
    errors     = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void write_reg(cfg_idx_e idx, logic [7:0] v);
    case (idx)
      CFG_MIN_CONF:   min_conf = v;
      CFG_STABLE_REP: stable_rep = v;
      CFG_TARGET:     target = v;
      default: ;
    endcase
  endfunction

  function bit digit_ok(logic [7:0] d);
    return d >= MIN_DIGIT && d <= MAX_DIGIT;
  endfunction

  function void take_frame(logic [7:0] r, logic [7:0] s, logic [7:0] f, logic [7:0] t,
                           logic [7:0] c);
    latest.room           = r;
    latest.side           = s;
    latest.found_flag     = f;
    latest.task_number    = t;
    latest.confidence     = c;
    latest.packet_count   = latest.packet_count + 32'd1;
    latest.frame_accepted = 1'b1;
    if (f == FOUND_YES && digit_ok(r) && s <= SIDE_MAX && c >= min_conf) begin
      if (cand_digit == r) begin
        if (cand_reps < REPEAT_CAP) cand_reps = cand_reps + 8'd1;
      end else begin
        cand_digit = r;
        cand_reps  = 8'd1;
      end
      if (cand_reps >= stable_rep) begin
        latest.locked_digit = r[3:0];
        latest.locked_flag  = 1'b1;
      end
    end else begin
      cand_digit = '0;
      cand_reps  = '0;
    end
  endfunction

  function void note_byte(logic mode, logic [7:0] b);
    logic [7:0] sum;
    latest.frame_accepted = 1'b0;
    latest.checksum_error = 1'b0;
    if (mode) begin
      latest.locked_digit = '0;
      latest.locked_flag  = 1'b0;
      cand_digit          = '0;
      cand_reps           = '0;
    end else begin
      case (pstate)
        PS_IDLE: begin
          if (b == HEAD_A) pstate = PS_A_ROOM;
          else if (b == HEAD_B1) pstate = PS_B_HEAD2;
        end
        PS_A_ROOM: begin
          h_room = b;
          pstate = PS_A_SIDE;
        end
        PS_A_SIDE: begin
          h_side = b;
          pstate = PS_A_CONF;
        end
        PS_A_CONF: begin
          h_conf = b;
          pstate = PS_A_SUM;
        end
        PS_A_SUM: begin
          h_sum  = b;
          pstate = PS_A_TAIL;
        end
        PS_A_TAIL: begin
          if (b == TAIL_A) begin
            sum = HEAD_A + h_room + h_side + h_conf;
            if (h_sum == sum) begin
              take_frame(h_room, h_side, FOUND_YES, 8'd0, h_conf);
            end else begin
              latest.checksum_error       = 1'b1;
              latest.checksum_error_count = latest.checksum_error_count + 32'd1;
            end
          end
          pstate = PS_IDLE;
        end
        PS_B_HEAD2: pstate = (b == HEAD_B2) ? PS_B_ROOM : PS_IDLE;
        PS_B_ROOM: begin
          h_room = b;
          pstate = PS_B_SIDE;
        end
        PS_B_SIDE: begin
          h_side = b;
          pstate = PS_B_FOUND;
        end
        PS_B_FOUND: begin
          h_found = b;
          pstate  = PS_B_TASK;
        end
        PS_B_TASK: begin
          h_task = b;
          pstate = PS_B_TAIL;
        end
        PS_B_TAIL: begin
          if (b == TAIL_B) take_frame(h_room, h_side, h_found, h_task, FIXED_CONF_B);
          pstate = PS_IDLE;
        end
        default: pstate = PS_IDLE;
      endcase
    end
    latest.target_matched = latest.found_flag == FOUND_YES && latest.room == target &&
                            digit_ok(latest.room);
    pending_results.push_back(latest);
  endfunction

  function void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check_result(result_t got);
    result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    cmp("frame_accepted", e.frame_accepted, got.frame_accepted);
    cmp("checksum_error", e.checksum_error, got.checksum_error);
    cmp("room", e.room, got.room);
    cmp("side", e.side, got.side);
    cmp("found_flag", e.found_flag, got.found_flag);
    cmp("task_number", e.task_number, got.task_number);
    cmp("confidence", e.confidence, got.confidence);
    cmp("locked_flag", e.locked_flag, got.locked_flag);
    cmp("locked_digit", e.locked_digit, got.locked_digit);
    cmp("target_matched", e.target_matched, got.target_matched);
    cmp("packet_count", e.packet_count, got.packet_count);
    cmp("checksum_error_count", e.checksum_error_count, got.checksum_error_count);
  endfunction
endclass

module dual_protocol_vision_frame_parser_tb;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RES_W-1:0]     m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [7:0]           cfg_data_i    = '0;

  frame_result_tracker tracker;
  int          beats_sent    = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  bit          mid_clear_en  = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [7:0]  fav_room      = 8'd1;

  dual_protocol_vision_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_not(logic [7:0] x);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == x) v = v ^ 8'h01;
    return v;
  endfunction

  function automatic logic [7:0] pick_room();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return fav_room;
    if (r < 80) return 8'($urandom_range(1, 8));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_side();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_found();
    if ($urandom_range(0, 6) != 0) return FOUND_YES;
    return 8'($urandom);
  endfunction

  // drain and check results; stall at random, or for a long hold on request
  initial begin
    int hold;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(result_t'(m_axis_tdata));
      if (long_hold_req) begin
        hold          = 300;
        long_hold_req = 1'b0;
      end else if (hold == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        hold = idle_len();
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_byte(mode, b);
    beats_sent++;
  endtask

  task automatic frame_beat(input logic [7:0] b);
    if (mid_clear_en && $urandom_range(0, 40) == 0) send_beat(1'b1, 8'($urandom));
    send_beat(1'b0, b);
  endtask

  task automatic send_frame_a(input logic [7:0] room, input logic [7:0] side,
                              input logic [7:0] conf, input bit bad_sum, input bit bad_tail);
    logic [7:0] sum;
    sum = HEAD_A + room + side + conf;
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    frame_beat(HEAD_A);
    frame_beat(room);
    frame_beat(side);
    frame_beat(conf);
    frame_beat(sum);
    frame_beat(bad_tail ? pick_not(TAIL_A) : TAIL_A);
  endtask

  task automatic send_frame_b(input logic [7:0] room, input logic [7:0] side,
                              input logic [7:0] found, input logic [7:0] tsk,
                              input bit bad_tail);
    frame_beat(HEAD_B1);
    frame_beat(HEAD_B2);
    frame_beat(room);
    frame_beat(side);
    frame_beat(found);
    frame_beat(tsk);
    frame_beat(bad_tail ? pick_not(TAIL_B) : TAIL_B);
  endtask

  task automatic random_unit();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_frame_a(pick_room(), pick_side(), 8'($urandom),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0);
    end else if (r < 75) begin
      send_frame_b(pick_room(), pick_side(), pick_found(), 8'($urandom),
                   $urandom_range(0, 9) == 0);
    end else if (r < 82) begin
      send_beat(1'b0, HEAD_B1);
      send_beat(1'b0, pick_not(HEAD_B2));
    end else if (r < 92) begin
      send_beat(1'b0, 8'($urandom));
    end else if (r < 96) begin
      send_beat(1'b1, 8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      send_beat(1'b0, ($urandom_range(0, 1) != 0) ? HEAD_A : HEAD_B1);
      repeat (n) send_beat(1'b0, 8'($urandom));
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] mc, input logic [7:0] sr,
                            input logic [7:0] tg);
    cfg_idx_e   idx[3];
    logic [7:0] val[3];
    idx = '{CFG_MIN_CONF, CFG_STABLE_REP, CFG_TARGET};
    val = '{mc, sr, tg};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int phase_end;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame_a(8'd8, 8'd2, 8'd255, 1'b0, 1'b0);
    send_frame_b(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    send_beat(1'b0, HEAD_A);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, 8'd1);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, TAIL_A);
    send_beat(1'b0, HEAD_B1);
    send_beat(1'b0, HEAD_A);
    send_frame_a(8'd1, 8'd1, 8'd54, 1'b0, 1'b1);
    settle();

    mid_clear_en = 1'b1;
    for (int p = 0; p < 12; p++) begin
      fav_room   = 8'($urandom_range(1, 8));
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      case (p)
        0: write_regs(8'd0, 8'd0, 8'd255);
        1: write_regs(8'd255, 8'd255, 8'd0);
        2: write_regs(8'd0, 8'd1, fav_room);
        default: begin
          write_regs(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110)),
                     8'($urandom_range(1, 5)), 8'($urandom_range(0, 9)));
        end
      endcase
      if (p == 3) begin
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
      end else if (p == 5) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      phase_end = beats_sent + 160;
      while (beats_sent < phase_end) random_unit();
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== dual_protocol_vision_frame_parser.f =====
rtl/dpvfp_pkg.sv
rtl/dpvfp_parser.sv
rtl/dpvfp_tracker.sv
rtl/dual_protocol_vision_frame_parser.sv
rtl/dpvfp_checker.sv
verif/dual_protocol_vision_frame_parser_tb.sv
